[sv/bed_pkg.sv]
// Shared types, constants and helpers for the bounded edit distance engine.
package bed_pkg;

	// Longest string that the cell row holds; one cell per reference character.
	localparam int MaxLen = 64;
	localparam int LenW   = $clog2(MaxLen + 1);
	localparam int ValW   = 7;
	localparam int CharW  = 8;
	localparam int SumW   = ((LenW > ValW) ? LenW : ValW) + 1;

	localparam logic [ValW-1:0] ValMax      = '1;
	localparam logic [ValW-1:0] CutoffReset = ValW'(2);

	typedef enum logic [1:0] {
		ReqStart  = 2'd0,
		ReqRef    = 2'd1,
		ReqQuery  = 2'd2,
		ReqFinish = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [CharW-1:0] char_code;
	} req_word_t;

	typedef struct packed {
		logic [ValW-1:0] distance;
		logic            cut_off;
		logic            too_long;
	} res_word_t;

	// Wavefront token handed from one cell to the next.
	typedef struct packed {
		logic             vld;
		logic [CharW-1:0] ch;
		logic [ValW-1:0]  left;
		logic [ValW-1:0]  diag;
		logic [ValW-1:0]  rmin;
	} wave_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic             ld;
		logic [CharW-1:0] ld_ch;
		logic [LenW-1:0]  ref_len;
	} cell_ctl_t;

	function automatic logic [ValW-1:0] sat_val(input logic [SumW-1:0] v);
		if (v > SumW'(ValMax)) begin
			return ValMax;
		end else begin
			return v[ValW-1:0];
		end
	endfunction

endpackage

[sv/bed_cell.sv]
// One column cell of the edit distance row: holds a reference character and its row value.
module bed_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bed_pkg::LenW-1:0]    idx,
	input  bed_pkg::cell_ctl_t          ctl,
	input  bed_pkg::wave_t              wave_in,
	output bed_pkg::wave_t              wave_out
);

	logic [bed_pkg::CharW-1:0] ch_q;
	logic [bed_pkg::ValW-1:0]  row_q;
	bed_pkg::wave_t            tok_q;

	logic                      active;
	logic                      load_hit;
	logic [bed_pkg::ValW-1:0]  m1;
	logic [bed_pkg::ValW-1:0]  mn;
	logic [bed_pkg::ValW-1:0]  v;
	logic [bed_pkg::ValW-1:0]  rmin_nxt;

	// A cell takes part in the row only while it lies within the reference string.
	assign active   = (idx <= ctl.ref_len);
	assign load_hit = ctl.ld && (ctl.ref_len == (idx - bed_pkg::LenW'(1)));

	always_comb begin
		m1 = (wave_in.left < row_q) ? wave_in.left : row_q;
		mn = (wave_in.diag < m1) ? wave_in.diag : m1;
		if (ch_q == wave_in.ch) begin
			v = wave_in.diag;
		end else begin
			v = bed_pkg::sat_val(bed_pkg::SumW'(mn) + bed_pkg::SumW'(1));
		end
		rmin_nxt = (v < wave_in.rmin) ? v : wave_in.rmin;
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			ch_q  <= ctl.ld_ch;
			row_q <= bed_pkg::sat_val(bed_pkg::SumW'(idx));
		end else if (wave_in.vld && active) begin
			row_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.vld <= 1'b0;
		end else begin
			tok_q.vld <= wave_in.vld;
			tok_q.ch  <= wave_in.ch;
			if (active) begin
				tok_q.left <= v;
				tok_q.diag <= row_q;
				tok_q.rmin <= rmin_nxt;
			end else begin
				tok_q.left <= wave_in.left;
				tok_q.diag <= wave_in.diag;
				tok_q.rmin <= wave_in.rmin;
			end
		end
	end

	assign wave_out = tok_q;

endmodule

[sv/bounded_edit_distance.sv]
// Top level of the bounded edit distance engine: request handling, cell row and result register.
//
// Usage: every request word on req (valid/stall) carries a kind and a character.
// A start word clears the pair, reference words append characters to the cell row,
// query words each launch one row of the distance matrix, and a finish word makes
// one result word on res (valid/stall). The cutoff register is written through the
// cfg channel (valid/ready, always ready); it resets to 2. The user must write it
// only while the engine is idle; the block itself does not enforce this. Start and
// reference words are taken when the row is idle. Query words are taken one per
// cycle: each sends a wavefront token down the row of MaxLen cells, one cell per cycle.
// Start, reference and finish words are held off (stall) while any token is still
// in the row. A finish word is taken once the row is empty and the result register
// is free, and its result appears on res the next cycle. While the receiver stalls,
// the result word is held and a further finish word waits; query words keep flowing.
// Asynchronous reset clears all control state and the cutoff returns to 2; the
// cell contents need no reset since a cell is only read after it has been loaded.
module bounded_edit_distance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bed_pkg::req_word_t            req,
	output logic                          res_valid,
	input  logic                          res_stall,
	output bed_pkg::res_word_t            res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bed_pkg::ValW-1:0]      cfg_data
);

	// Configuration and pair bookkeeping.
	logic [bed_pkg::ValW-1:0]  cutoff_q;
	logic [bed_pkg::LenW-1:0]  ref_len_q;
	logic [bed_pkg::LenW-1:0]  qcnt_q;
	logic                      cut_q;
	logic                      ovf_q;
	logic [bed_pkg::ValW-1:0]  row0_q;
	logic [bed_pkg::ValW-1:0]  last_q;

	// Head of the wavefront: the column zero entry of each new row.
	bed_pkg::wave_t            head_q;
	bed_pkg::wave_t            wave [bed_pkg::MaxLen+1];
	logic [bed_pkg::MaxLen:0]  wave_vld;
	bed_pkg::cell_ctl_t        cell_ctl;

	logic                      res_valid_q;
	bed_pkg::res_word_t        res_q;

	logic                      busy;
	logic                      out_free;
	logic                      acc;
	logic                      launch;
	logic                      is_ref;
	logic                      is_query;
	logic                      is_finish;
	logic [bed_pkg::ValW-1:0]  left0;
	logic [bed_pkg::ValW-1:0]  fin_dist;

	assign is_ref    = (req.req_type == bed_pkg::ReqRef);
	assign is_query  = (req.req_type == bed_pkg::ReqQuery);
	assign is_finish = (req.req_type == bed_pkg::ReqFinish);

	assign busy      = |wave_vld;
	assign out_free  = !res_valid_q || !res_stall;

	// Only query words may enter while tokens are in flight; a finish also needs
	// room in the result register.
	assign req_stall = (busy && !is_query) || (is_finish && !out_free);
	assign acc       = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// A query word starts a new row unless the query string is already full.
	assign launch    = acc && is_query && (qcnt_q < bed_pkg::LenW'(bed_pkg::MaxLen));

	// First entry of the new row is the number of query characters so far plus one.
	assign left0 = bed_pkg::sat_val(bed_pkg::SumW'(qcnt_q) + bed_pkg::SumW'(1));

	// A reference character goes to the cell just past the current length.
	assign cell_ctl.ld      = acc && is_ref && (qcnt_q == '0) &&
	                          (ref_len_q < bed_pkg::LenW'(bed_pkg::MaxLen));
	assign cell_ctl.ld_ch   = req.char_code;
	assign cell_ctl.ref_len = ref_len_q;

	always_comb begin
		if (cut_q) begin
			fin_dist = bed_pkg::sat_val(bed_pkg::SumW'(cutoff_q) + bed_pkg::SumW'(1));
		end else if (qcnt_q == '0) begin
			fin_dist = bed_pkg::sat_val(bed_pkg::SumW'(ref_len_q));
		end else begin
			fin_dist = last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q  <= bed_pkg::CutoffReset;
			ref_len_q <= '0;
			qcnt_q    <= '0;
			cut_q     <= 1'b0;
			ovf_q     <= 1'b0;
			row0_q    <= '0;
			head_q.vld <= 1'b0;
		end else begin
			head_q.vld <= launch;
			if (cfg_valid && cfg_ready) begin
				cutoff_q <= cfg_data;
			end
			// The token leaving the last cell carries the row minimum and the
			// value at the reference length.
			if (wave[bed_pkg::MaxLen].vld && (wave[bed_pkg::MaxLen].rmin > cutoff_q)) begin
				cut_q <= 1'b1;
			end
			if (acc) begin
				case (req.req_type)
					bed_pkg::ReqStart: begin
						ref_len_q <= '0;
						qcnt_q    <= '0;
						cut_q     <= 1'b0;
						ovf_q     <= 1'b0;
						row0_q    <= '0;
					end
					bed_pkg::ReqRef: begin
						if (qcnt_q == '0) begin
							if (ref_len_q >= bed_pkg::LenW'(bed_pkg::MaxLen)) begin
								ovf_q <= 1'b1;
							end else begin
								ref_len_q <= ref_len_q + bed_pkg::LenW'(1);
							end
						end
					end
					bed_pkg::ReqQuery: begin
						if (qcnt_q >= bed_pkg::LenW'(bed_pkg::MaxLen)) begin
							ovf_q <= 1'b1;
						end else begin
							// Rows after a cutoff are still computed; the result
							// ignores them since the cut flag is sticky.
							qcnt_q      <= qcnt_q + bed_pkg::LenW'(1);
							row0_q      <= left0;
							head_q.ch   <= req.char_code;
							head_q.left <= left0;
							head_q.diag <= row0_q;
							head_q.rmin <= left0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wave[bed_pkg::MaxLen].vld) begin
			last_q <= wave[bed_pkg::MaxLen].left;
		end
	end

	assign wave[0]     = head_q;
	assign wave_vld[0] = head_q.vld;

	for (genvar g = 1; g <= bed_pkg::MaxLen; g++) begin : g_cell
		bed_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (bed_pkg::LenW'(g)),
			.ctl      (cell_ctl),
			.wave_in  (wave[g-1]),
			.wave_out (wave[g])
		);
		assign wave_vld[g] = wave[g].vld;
	end

	// Result register: loaded by a finish word, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (acc && is_finish) begin
				res_valid_q    <= 1'b1;
				res_q.distance <= fin_dist;
				res_q.cut_off  <= cut_q;
				res_q.too_long <= ovf_q;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A finish word must never be taken while a row is still in the cells.
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && is_finish) |-> !busy)
		else $error("finish taken while the cell row is busy");

	// The reference length never grows past the number of cells.
	a_ref_len: assert property (@(posedge clk) disable iff (!arst_n)
		ref_len_q <= bed_pkg::LenW'(bed_pkg::MaxLen))
		else $error("reference length beyond the cell row");

	// A cut-off result always reports a nonzero distance.
	a_cut_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.cut_off) |-> (res.distance != '0))
		else $error("cut-off result with zero distance");

	// A reference word never changes the length once a query has been taken.
	a_ref_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && is_ref && (qcnt_q != '0)) |=> $stable(ref_len_q))
		else $error("reference length changed after a query");

endmodule

[tb/bounded_edit_distance_test.sv]
// Self-checking testbench for the bounded edit distance engine.
`timescale 1ns / 100ps

module bounded_edit_distance_test;
	import bed_pkg::*;

	// Long receiver hold-off used to back the engine up into its request port.
	localparam int HoldCycles  = 300;
	// Long enough for a query token to leave the row, so this covers any work in flight.
	localparam int DrainCycles = MaxLen + 16;
	// Words and finish words per cutoff setting in the random part.
	localparam int PhaseWords    = 55;
	localparam int PhaseFinishes = 5;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	req_word_t       req       = '0;
	logic            res_valid;
	logic            res_stall;
	res_word_t       res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [ValW-1:0] cfg_data  = '0;

	// The receiver stalls either at random or during the long hold-off.
	logic rx_stall_rand = 1'b0;
	logic long_hold     = 1'b0;
	assign res_stall = rx_stall_rand | long_hold;

	// Words waiting to be offered, and the results that the accepted words must produce.
	req_word_t word_q [$];
	res_word_t dist_expect_q [$];

	// Shadow of the engine: reference bytes, the current matrix row and the pair flags.
	logic [CharW-1:0] ref_bytes [MaxLen];
	logic [ValW-1:0]  row_val [MaxLen+1];
	int               ref_len;
	int               qry_count;
	bit               cut_seen;
	bit               ovf_seen;
	logic [ValW-1:0]  cutoff_q = CutoffReset;

	// When set, neither side idles.
	bit calm = 1'b0;
	int hold_requests = 0;

	int errors = 0;
	int items_pushed = 0;
	int finishes_pushed = 0;
	int words_sent = 0;
	int results_seen = 0;
	int cut_results = 0;
	int long_results = 0;
	int settings_done = 0;

	bounded_edit_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// A run that hangs waiting for a handshake ends here.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		errors++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic int clamp7(input int v);
		return (v > int'(ValMax)) ? int'(ValMax) : v;
	endfunction

	// Most gaps are zero; about one in eight of the others is long.
	function automatic int pick_gap(input int busy_pct);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r >= busy_pct) begin
			return 0;
		end
		if (r < busy_pct / 8) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// One query byte: compute the next matrix row from the current one, in place.
	// The diagonal neighbor is the old value of the cell to the left, the upper
	// neighbor the old value of the same cell, and the left one the new value.
	function automatic void advance_row(input logic [CharW-1:0] c);
		int diag;
		int left;
		int up;
		int v;
		int row_min;
		diag = row_val[0];
		left = clamp7(qry_count + 1);
		row_min = left;
		row_val[0] = ValW'(left);
		for (int j = 1; j <= ref_len; j++) begin
			up = row_val[j];
			if (ref_bytes[j-1] == c) begin
				v = diag;
			end else begin
				v = left;
				if (up < v) begin
					v = up;
				end
				if (diag < v) begin
					v = diag;
				end
				v = clamp7(v + 1);
			end
			row_val[j] = ValW'(v);
			diag = up;
			left = v;
			if (v < row_min) begin
				row_min = v;
			end
		end
		// Once every entry of a row is above the cutoff, the distance can only grow.
		if (row_min > int'(cutoff_q)) begin
			cut_seen = 1'b1;
		end
	endfunction

	// Update the shadow for one accepted word; a finish word queues its expected result.
	task automatic predict_word(input req_word_t w);
		res_word_t r;
		int d;
		case (req_kind_t'(w.req_type))
			ReqStart: begin
				// The cutoff survives a new pair; everything else starts over.
				ref_len = 0;
				qry_count = 0;
				cut_seen = 1'b0;
				ovf_seen = 1'b0;
				row_val[0] = '0;
			end
			ReqRef: begin
				// Reference bytes are ignored once the rows are under way.
				if (qry_count == 0) begin
					if (ref_len >= MaxLen) begin
						ovf_seen = 1'b1;
					end else begin
						ref_bytes[ref_len] = w.char_code;
						ref_len++;
						row_val[ref_len] = ValW'(clamp7(ref_len));
					end
				end
			end
			ReqQuery: begin
				// After a cut off, query bytes still count toward the length check.
				if (qry_count >= MaxLen) begin
					ovf_seen = 1'b1;
				end else begin
					if (!cut_seen) begin
						advance_row(w.char_code);
					end
					qry_count++;
				end
			end
			default: begin
				// Finish leaves the state alone, so a second finish repeats the result.
				if (cut_seen) begin
					d = clamp7(int'(cutoff_q) + 1);
				end else if (qry_count == 0) begin
					d = clamp7(ref_len);
				end else begin
					d = row_val[ref_len];
				end
				r.distance = ValW'(d);
				r.cut_off = cut_seen;
				r.too_long = ovf_seen;
				dist_expect_q.push_back(r);
			end
		endcase
	endtask

	// Request driver: offers queued words with random gaps and holds a word until taken.
	always @(posedge clk or negedge arst_n) begin : req_driver
		req_word_t nxt_word;
		logic nxt_valid;
		int gap_left;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
			ref_len = 0;
			qry_count = 0;
			cut_seen = 1'b0;
			ovf_seen = 1'b0;
			for (int i = 0; i < MaxLen; i++) begin
				ref_bytes[i] = '0;
			end
			for (int i = 0; i <= MaxLen; i++) begin
				row_val[i] = '0;
			end
		end else begin
			nxt_valid = req_valid;
			nxt_word = req;
			if (req_valid && !req_stall) begin
				predict_word(req);
				words_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (word_q.size() != 0) begin
					nxt_word = word_q.pop_front();
					nxt_valid = 1'b1;
					gap_left = pick_gap(40);
				end
			end
			req_valid <= nxt_valid;
			req <= nxt_word;
		end
	end

	// Result monitor: checks each taken result against the oldest expectation and
	// drives the random part of the receiver stall.
	always @(posedge clk or negedge arst_n) begin : res_monitor
		res_word_t want;
		int stall_left;
		if (!arst_n) begin
			rx_stall_rand <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (dist_expect_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result distance %0d cut %0b long %0b",
						res.distance, res.cut_off, res.too_long));
				end else begin
					want = dist_expect_q.pop_front();
					results_seen++;
					if (want.cut_off) begin
						cut_results++;
					end
					if (want.too_long) begin
						long_results++;
					end
					if (res.distance !== want.distance) begin
						flag_mismatch($sformatf("distance %0d, expected %0d",
							res.distance, want.distance));
					end
					if (res.cut_off !== want.cut_off) begin
						flag_mismatch($sformatf("cut_off %0b, expected %0b",
							res.cut_off, want.cut_off));
					end
					if (res.too_long !== want.too_long) begin
						flag_mismatch($sformatf("too_long %0b, expected %0b",
							res.too_long, want.too_long));
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rx_stall_rand <= 1'b1;
			end else begin
				stall_left = pick_gap(35);
				rx_stall_rand <= 1'b0;
			end
		end
	end

	// Long hold-off of the receiver, started by the stimulus and counted here.
	always @(posedge clk or negedge arst_n) begin : res_hold
		int hold_left;
		int holds_done;
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left = 0;
			holds_done = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) begin
				long_hold <= 1'b0;
			end
		end else if (hold_requests != holds_done) begin
			holds_done++;
			hold_left = HoldCycles;
			long_hold <= 1'b1;
		end
	end

	task automatic push_word(input req_kind_t kind, input logic [CharW-1:0] ch);
		req_word_t w;
		w.req_type = kind;
		w.char_code = ch;
		word_q.push_back(w);
		items_pushed++;
		if (kind == ReqFinish) begin
			finishes_pushed++;
		end
	endtask

	// Half the bytes come from a two-letter set in both cases, so matches and
	// case-only mismatches are frequent; the rest are extremes or fully random.
	function automatic logic [CharW-1:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return CharW'($urandom_range(0, 1)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
		end
		if (r == 5) begin
			return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
		end
		return CharW'($urandom_range(0, 255));
	endfunction

	// Mostly a well-formed pair with random content; now and then a missing start,
	// a stray reference byte among the queries, a repeated finish or noise words.
	// A few pairs run past MaxLen on either side.
	task automatic push_pair();
		int nref;
		int nqry;
		if ($urandom_range(0, 19) != 0) begin
			push_word(ReqStart, pick_char());
		end
		nref = ($urandom_range(0, 19) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 6);
		nqry = ($urandom_range(0, 19) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 6);
		repeat (nref) begin
			push_word(ReqRef, pick_char());
		end
		repeat (nqry) begin
			push_word(ReqQuery, pick_char());
			if ($urandom_range(0, 29) == 0) begin
				push_word(ReqRef, pick_char());
			end
		end
		push_word(ReqFinish, pick_char());
		if ($urandom_range(0, 9) == 0) begin
			push_word(ReqFinish, pick_char());
		end
		if ($urandom_range(0, 14) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				push_word(req_kind_t'($urandom_range(0, 3)), pick_char());
			end
		end
	endtask

	// Wait until every queued word is taken and every expected result has come.
	task automatic wait_drained();
		@(posedge clk);
		while (word_q.size() != 0 || req_valid || dist_expect_q.size() != 0 || res_valid) begin
			@(posedge clk);
		end
	endtask

	// Before touching the cutoff, also let any query tokens leave the cell row,
	// since they produce no result that would tell us they are done.
	task automatic wait_idle();
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_cutoff(input logic [ValW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cutoff_q = v;
		settings_done++;
	endtask

	initial begin : stimulus
		logic [ValW-1:0] cutoffs [6];
		int phase_words;
		int phase_finishes;
		cutoffs = '{ValW'(0), ValW'(127), ValW'(64), ValW'(1), ValW'(0), ValW'(2)};
		cutoffs[4] = ValW'($urandom_range(0, 127));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, under the cutoff left by reset. A finish straight out of
		// reset reports an empty pair.
		push_word(ReqFinish, 8'h00);
		// "abc" against "aXcd": a match, a substitution, a match, an insertion.
		push_word(ReqStart, 8'hFF);
		push_word(ReqRef, 8'h61);
		push_word(ReqRef, 8'h62);
		push_word(ReqRef, 8'h63);
		push_word(ReqQuery, 8'h61);
		push_word(ReqQuery, 8'h58);
		push_word(ReqQuery, 8'h63);
		push_word(ReqQuery, 8'h64);
		push_word(ReqFinish, 8'h00);
		// A reference byte after the queries is dropped, and a second finish repeats.
		push_word(ReqRef, 8'h7A);
		push_word(ReqFinish, 8'hFF);
		// Byte extremes; with no query the distance is the reference length.
		push_word(ReqStart, 8'h00);
		push_word(ReqRef, 8'h61);
		push_word(ReqRef, 8'hFF);
		push_word(ReqRef, 8'h00);
		push_word(ReqFinish, 8'h00);
		// Upper case against lower case must not match.
		push_word(ReqQuery, 8'h41);
		push_word(ReqQuery, 8'hFF);
		push_word(ReqFinish, 8'h00);
		// Empty pair after a start.
		push_word(ReqStart, 8'h00);
		push_word(ReqFinish, 8'h00);

		// Random part: one stretch per cutoff setting, the extremes among them.
		// One stretch runs with no idling on either side.
		foreach (cutoffs[p]) begin
			wait_idle();
			write_cutoff(cutoffs[p]);
			calm = (p == 2);
			phase_words = items_pushed;
			phase_finishes = finishes_pushed;
			while (items_pushed - phase_words < PhaseWords ||
					finishes_pushed - phase_finishes < PhaseFinishes) begin
				push_pair();
				// Now and then the sender pauses until every result is back.
				if ($urandom_range(0, 7) == 0) begin
					wait_drained();
				end
			end
		end

		// Back-pressure: the receiver holds off while short pairs keep coming, so
		// the first result sits in the output register and the next finish stalls
		// the request port with further words queued behind it.
		wait_idle();
		calm = 1'b1;
		hold_requests <= hold_requests + 1;
		repeat (3) begin
			push_word(ReqStart, pick_char());
			push_word(ReqRef, pick_char());
			push_word(ReqRef, pick_char());
			push_word(ReqQuery, pick_char());
			push_word(ReqQuery, pick_char());
			push_word(ReqFinish, pick_char());
		end
		wait_drained();
		calm = 1'b0;

		wait_idle();
		$display("Ran %0d request words under %0d cutoff settings and checked %0d results.",
			words_sent, settings_done, results_seen);
		$display("Of those, %0d were cut off and %0d reported an over-long string.",
			cut_results, long_results);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[bounded_edit_distance.f]
sv/bed_pkg.sv
sv/bed_cell.sv
sv/bounded_edit_distance.sv
tb/bounded_edit_distance_test.sv
